// File: sv/assert_macros.svh
// Assertion macros shared by the arc_cache_replacement RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_AT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/arc_pkg.sv
// Shared types, codes and helpers for the ARC directory.
package arc_pkg;

  localparam int PAGE_W  = 32;
  localparam int CAP_W   = 7;
  localparam int TGT_W   = 15;
  localparam int TOTAL_W = 32;

  // List membership of a directory entry.
  typedef enum logic [2:0] {
    L_NONE = 3'd0,
    L_T1   = 3'd1,
    L_T2   = 3'd2,
    L_B1   = 3'd3,
    L_B2   = 3'd4
  } list_t;

  // Request outcome codes.
  typedef enum logic [1:0] {
    OC_HIT  = 2'd0,
    OC_B1   = 2'd1,
    OC_B2   = 2'd2,
    OC_MISS = 2'd3
  } outcome_t;

  // Command broadcast to every directory cell.
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_UNLINK = 2'd1,
    OP_PUSH   = 2'd2,
    OP_FLUSH  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    list_t    lst;
    logic     wr_tag;
  } cell_cmd_t;

  // Request sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DEC,
    S_DIV,
    S_ADAPT,
    S_NEXT,
    S_OPW,
    S_OPU,
    S_OPP,
    S_FIN,
    S_FIN2,
    S_DONE
  } state_t;

  // Index of a list's counter: T1, T2, B1, B2 map to 0..3.
  function automatic logic [1:0] lidx(list_t l);
    logic [2:0] v;
    v = l;
    return v[1:0] - 2'd1;
  endfunction

endpackage

// File: sv/arc_cell.sv
// One directory cell: tag, list membership and recency rank of a single entry.
module arc_cell #(
  parameter int IW  = 7,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  arc_pkg::cell_cmd_t cmd,
  input  logic [IW-1:0]     cmd_idx,
  input  logic [IW-1:0]     cmd_rank,
  input  logic [31:0]       cmd_tag,
  input  logic [31:0]       key,
  input  arc_pkg::list_t    q_list,
  input  logic [IW-1:0]     q_rank,
  input  logic              free_in,
  output logic              free_out,
  output logic              claim,
  output logic              match,
  output logic              lru_hit,
  output arc_pkg::list_t    list_o,
  output logic [IW-1:0]     rank_o,
  output logic [31:0]       tag_o
);
  import arc_pkg::*;

  list_t         list_r, list_nxt;
  logic [IW-1:0] rank_r, rank_nxt;
  logic [31:0]   tag_r;
  logic          sel;
  logic          free;

  assign sel  = (cmd_idx == IW'(IDX));
  assign free = (list_r == L_NONE);

  always_comb begin
    list_nxt = list_r;
    rank_nxt = rank_r;
    case (cmd.op)
      OP_FLUSH: begin
        list_nxt = L_NONE;
        rank_nxt = '0;
      end
      OP_UNLINK: begin
        if (sel) begin
          list_nxt = L_NONE;
          rank_nxt = '0;
        end else if (list_r == cmd.lst && rank_r > cmd_rank) begin
          rank_nxt = rank_r - IW'(1);
        end
      end
      OP_PUSH: begin
        if (sel) begin
          list_nxt = cmd.lst;
          rank_nxt = '0;
        end else if (list_r == cmd.lst) begin
          rank_nxt = rank_r + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_r <= L_NONE;
      rank_r <= '0;
    end else begin
      list_r <= list_nxt;
      rank_r <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH && sel && cmd.wr_tag) begin
      tag_r <= cmd_tag;
    end
  end

  // The free chain hands "a lower cell is free" to the next cell up.
  assign free_out = free_in | free;
  assign claim    = free & ~free_in;
  assign match    = !free && (tag_r == key);
  assign lru_hit  = !free && (list_r == q_list) && (rank_r == q_rank);
  assign list_o   = list_r;
  assign rank_o   = rank_r;
  assign tag_o    = tag_r;

endmodule

// File: sv/arc_cache_replacement.sv
// ARC directory top level: a row of directory cells driven by a request sequencer.
// A request is looked up and decoded; a resident hit then moves to the head of T2.
// A miss may first trim a list and replace a page, then goes into T1. A ghost hit
// adapts the target (dividing first if a ratio is needed), replaces, then joins T2.
// One item at a time; a waiting result holds the sequencer.
// Reset: synchronous active-low; all lists empty, target zero, capacity 64, counters zero.
`include "assert_macros.svh"
module arc_cache_replacement #(
  parameter int MAX_PAGES = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [arc_pkg::PAGE_W-1:0]   in_page,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_outcome,
  output logic                         out_hit,
  output logic                         out_evict_valid,
  output logic [arc_pkg::PAGE_W-1:0]   out_evict_page,
  output logic [arc_pkg::TGT_W-1:0]    out_target_size,
  output logic [arc_pkg::TOTAL_W-1:0]  out_hit_total,
  input  logic                         cfg_wr_en,
  input  logic [arc_pkg::CAP_W-1:0]    cfg_wr_data
);
  import arc_pkg::*;

  // The directory holds twice the resident capacity: T1, T2 plus the ghost lists.
  localparam int DIR = 2 * MAX_PAGES;
  localparam int IW  = $clog2(DIR);
  localparam int CW  = $clog2(DIR + 1);
  localparam int EW  = CW + 2;
  localparam int NW  = CW + FRAC_BITS;
  localparam int TW  = $clog2(MAX_PAGES + 1) + FRAC_BITS;
  localparam int DCW = $clog2(NW);

  // Sequencer and bookkeeping state.
  state_t            state_r, state_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [TW-1:0]     tgt_r, tgt_nxt;
  logic [CW-1:0]     cnt_r [4];
  logic [CW-1:0]     cnt_nxt [4];
  logic [31:0]       hits_r, hits_nxt;
  outcome_t          outcome_r, outcome_nxt;
  logic              ev_v_r, ev_v_nxt;
  logic [31:0]       ev_pg_r, ev_pg_nxt;
  logic              need_drop_r, need_drop_nxt;
  list_t             drop_list_r, drop_list_nxt;
  logic              drop_ev_r, drop_ev_nxt;
  logic              need_rep_r, need_rep_nxt;
  logic              rep_b2_r, rep_b2_nxt;
  list_t             op_from_r, op_from_nxt;
  list_t             op_to_r, op_to_nxt;
  logic              op_ev_r, op_ev_nxt;
  logic [IW-1:0]     q_rank_r, q_rank_nxt;
  logic [NW-1:0]     div_num_r, div_num_nxt;
  logic [CW-1:0]     div_den_r, div_den_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [DCW-1:0]    div_cnt_r, div_cnt_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  outcome_t          out_outcome_r;
  logic              out_ev_v_r;
  logic [31:0]       out_ev_pg_r;
  logic [TW-1:0]     out_tgt_r;
  logic [31:0]       out_hits_r;

  // Registered reductions over the cell row.
  logic              fnd_any_r, fnd_any;
  list_t             fnd_list_r, fnd_list;
  logic [IW-1:0]     fnd_rank_r, fnd_rank;
  logic [IW-1:0]     fnd_idx_r, fnd_idx;
  logic              lru_any_r, lru_any;
  logic [IW-1:0]     lru_idx_r, lru_idx;
  logic [31:0]       lru_tag_r, lru_tag;
  logic              free_any_r;
  logic [IW-1:0]     free_idx_r, free_idx;

  // Cell row wiring.
  cell_cmd_t         cmd;
  logic [IW-1:0]     cmd_idx, cmd_rank;
  logic              c_free [DIR+1];
  logic              c_claim [DIR];
  logic              c_match [DIR];
  logic              c_lru [DIR];
  list_t             c_list [DIR];
  logic [IW-1:0]     c_rank [DIR];
  logic [31:0]       c_tag [DIR];

  assign c_free[0] = 1'b0;

  for (genvar g = 0; g < DIR; g++) begin : g_cell
    arc_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .cmd_idx  (cmd_idx),
      .cmd_rank (cmd_rank),
      .cmd_tag  (key_r),
      .key      (key_r),
      .q_list   (op_from_r),
      .q_rank   (q_rank_r),
      .free_in  (c_free[g]),
      .free_out (c_free[g+1]),
      .claim    (c_claim[g]),
      .match    (c_match[g]),
      .lru_hit  (c_lru[g]),
      .list_o   (c_list[g]),
      .rank_o   (c_rank[g]),
      .tag_o    (c_tag[g])
    );
  end

  // Tags are unique among live entries, and so are (list, rank) pairs, so the
  // lookups reduce to plain ORs of the one selected cell.
  always_comb begin
    logic [2:0] lbits;
    fnd_any  = 1'b0;
    lbits    = '0;
    fnd_rank = '0;
    fnd_idx  = '0;
    lru_any  = 1'b0;
    lru_idx  = '0;
    lru_tag  = '0;
    free_idx = '0;
    for (int i = 0; i < DIR; i++) begin
      fnd_any  = fnd_any | c_match[i];
      lbits    = lbits | ({3{c_match[i]}} & c_list[i]);
      fnd_rank = fnd_rank | ({IW{c_match[i]}} & c_rank[i]);
      fnd_idx  = fnd_idx | ({IW{c_match[i]}} & IW'(i));
      lru_any  = lru_any | c_lru[i];
      lru_idx  = lru_idx | ({IW{c_lru[i]}} & IW'(i));
      lru_tag  = lru_tag | ({32{c_lru[i]}} & c_tag[i]);
      free_idx = free_idx | ({IW{c_claim[i]}} & IW'(i));
    end
    fnd_list = list_t'(lbits);
  end

  // Effective capacity: zero acts as one, values above MAX_PAGES saturate at MAX_PAGES.
  logic [CW-1:0] cap_eff;
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_r) > 32'(MAX_PAGES)) begin
      cap_eff = CW'(MAX_PAGES);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  logic [NW-1:0] cf;
  assign cf = {cap_eff, {FRAC_BITS{1'b0}}};

  // List sizes and the case IV quantities.
  logic [CW-1:0] t1, t2, b1, b2;
  logic [EW-1:0] l1, tot, ce, c2;
  assign t1  = cnt_r[0];
  assign t2  = cnt_r[1];
  assign b1  = cnt_r[2];
  assign b2  = cnt_r[3];
  assign l1  = EW'(t1) + EW'(b1);
  assign tot = l1 + EW'(t2) + EW'(b2);
  assign ce  = EW'(cap_eff);
  assign c2  = EW'(cap_eff) << 1;

  logic is_res, is_ghost, in_b2, need_div;
  assign is_res   = fnd_any_r && (fnd_list_r == L_T1 || fnd_list_r == L_T2);
  assign is_ghost = fnd_any_r && !is_res;
  assign in_b2    = (fnd_list_r == L_B2);
  assign need_div = in_b2 ? (b2 < b1 && b2 != '0) : (b1 < b2 && b1 != '0);

  // REPLACE: demote T1's LRU if T1 > target (or == on a B2 hit), else T2's LRU.
  logic [NW-1:0] t1f, pz;
  logic          rep_t1;
  list_t         nx_from, nx_to;
  logic          nx_ev, nx_busy, nx_go;
  assign t1f     = {t1, {FRAC_BITS{1'b0}}};
  assign pz      = NW'(tgt_r);
  assign rep_t1  = (t1 != '0) && (t1f > pz || (rep_b2_r && t1f == pz));
  assign nx_from = need_drop_r ? drop_list_r : (rep_t1 ? L_T1 : L_T2);
  assign nx_to   = need_drop_r ? L_NONE : (rep_t1 ? L_B1 : L_B2);
  assign nx_ev   = need_drop_r ? drop_ev_r : 1'b1;
  assign nx_busy = need_drop_r || need_rep_r;
  assign nx_go   = nx_busy && (cnt_r[lidx(nx_from)] != '0);

  // Bit-serial restoring divider step.
  logic [CW:0] rem_s;
  logic        qbit;
  assign rem_s = {rem_r, div_num_r[NW-1]};
  assign qbit  = (rem_s >= {1'b0, div_den_r});

  // Target adaptation.
  logic [NW:0] p_sum;
  assign p_sum = {1'b0, pz} + {1'b0, div_num_r};

  logic ld_out;
  assign ld_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_DEC;
      S_DEC: begin
        if (is_ghost) begin
          state_nxt = need_div ? S_DIV : S_ADAPT;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIV:   if (div_cnt_r == DCW'(NW - 1)) state_nxt = S_ADAPT;
      S_ADAPT: state_nxt = S_NEXT;
      S_NEXT: begin
        if (nx_go) begin
          state_nxt = S_OPW;
        end else if (!nx_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_OPW:   state_nxt = S_OPU;
      S_OPU:   state_nxt = (op_to_r != L_NONE) ? S_OPP : S_NEXT;
      S_OPP:   state_nxt = S_NEXT;
      S_FIN:   state_nxt = (outcome_r == OC_MISS) ? S_DONE : S_FIN2;
      S_FIN2:  state_nxt = S_DONE;
      S_DONE:  if (ld_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Cell commands issued by the sequencer; a capacity write flushes the row.
  always_comb begin
    cmd      = '{op: OP_NONE, lst: L_NONE, wr_tag: 1'b0};
    cmd_idx  = '0;
    cmd_rank = '0;
    if (cfg_wr_en) begin
      cmd.op = OP_FLUSH;
    end else begin
      case (state_r)
        S_OPU: begin
          cmd.op   = OP_UNLINK;
          cmd.lst  = op_from_r;
          cmd_idx  = lru_idx_r;
          cmd_rank = q_rank_r;
        end
        S_OPP: begin
          cmd.op  = OP_PUSH;
          cmd.lst = op_to_r;
          cmd_idx = lru_idx_r;
        end
        S_FIN: begin
          if (outcome_r == OC_MISS) begin
            cmd.op     = OP_PUSH;
            cmd.lst    = L_T1;
            cmd.wr_tag = 1'b1;
            cmd_idx    = free_idx_r;
          end else begin
            cmd.op   = OP_UNLINK;
            cmd.lst  = fnd_list_r;
            cmd_idx  = fnd_idx_r;
            cmd_rank = fnd_rank_r;
          end
        end
        S_FIN2: begin
          cmd.op  = OP_PUSH;
          cmd.lst = L_T2;
          cmd_idx = fnd_idx_r;
        end
        default: ;
      endcase
    end
  end

  // Datapath next values.
  always_comb begin
    key_nxt       = key_r;
    cap_nxt       = cap_r;
    tgt_nxt       = tgt_r;
    cnt_nxt       = cnt_r;
    hits_nxt      = hits_r;
    outcome_nxt   = outcome_r;
    ev_v_nxt      = ev_v_r;
    ev_pg_nxt     = ev_pg_r;
    need_drop_nxt = need_drop_r;
    drop_list_nxt = drop_list_r;
    drop_ev_nxt   = drop_ev_r;
    need_rep_nxt  = need_rep_r;
    rep_b2_nxt    = rep_b2_r;
    op_from_nxt   = op_from_r;
    op_to_nxt     = op_to_r;
    op_ev_nxt     = op_ev_r;
    q_rank_nxt    = q_rank_r;
    div_num_nxt   = div_num_r;
    div_den_nxt   = div_den_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_page;
          ev_v_nxt  = 1'b0;
          ev_pg_nxt = '0;
        end
      end
      S_DEC: begin
        need_drop_nxt = 1'b0;
        need_rep_nxt  = 1'b0;
        rep_b2_nxt    = 1'b0;
        drop_ev_nxt   = 1'b0;
        drop_list_nxt = L_B1;
        rem_nxt       = '0;
        div_cnt_nxt   = '0;
        if (is_res) begin
          outcome_nxt = OC_HIT;
          hits_nxt    = hits_r + 32'd1;
        end else if (is_ghost) begin
          outcome_nxt  = in_b2 ? OC_B2 : OC_B1;
          need_rep_nxt = 1'b1;
          rep_b2_nxt   = in_b2;
          div_den_nxt  = in_b2 ? b2 : b1;
          if (need_div) begin
            div_num_nxt = {(in_b2 ? b1 : b2), {FRAC_BITS{1'b0}}};
          end else begin
            div_num_nxt = NW'(1) << FRAC_BITS;
          end
        end else begin
          outcome_nxt = OC_MISS;
          // Case IV: keep L1 within c and the directory within 2c.
          if (l1 == ce) begin
            need_drop_nxt = 1'b1;
            if (EW'(t1) < ce) begin
              drop_list_nxt = L_B1;
              need_rep_nxt  = 1'b1;
            end else begin
              drop_list_nxt = L_T1;
              drop_ev_nxt   = 1'b1;
            end
          end else if (tot >= ce) begin
            need_drop_nxt = (tot == c2);
            drop_list_nxt = L_B2;
            need_rep_nxt  = 1'b1;
          end
        end
      end
      S_DIV: begin
        div_num_nxt = {div_num_r[NW-2:0], qbit};
        rem_nxt     = qbit ? CW'(rem_s - {1'b0, div_den_r}) : CW'(rem_s);
        div_cnt_nxt = div_cnt_r + DCW'(1);
      end
      S_ADAPT: begin
        if (outcome_r == OC_B2) begin
          tgt_nxt = (pz > div_num_r) ? TW'(pz - div_num_r) : '0;
        end else begin
          tgt_nxt = (p_sum > {1'b0, cf}) ? TW'(cf) : TW'(p_sum);
        end
      end
      S_NEXT: begin
        if (nx_busy) begin
          if (need_drop_r) begin
            need_drop_nxt = 1'b0;
          end else begin
            need_rep_nxt = 1'b0;
          end
          op_from_nxt = nx_from;
          op_to_nxt   = nx_to;
          op_ev_nxt   = nx_ev;
          q_rank_nxt  = IW'(cnt_r[lidx(nx_from)] - CW'(1));
        end
      end
      S_OPU: begin
        cnt_nxt[lidx(op_from_r)] = cnt_r[lidx(op_from_r)] - CW'(1);
        if (op_ev_r) begin
          ev_v_nxt  = 1'b1;
          ev_pg_nxt = lru_tag_r;
        end
      end
      S_OPP: begin
        cnt_nxt[lidx(op_to_r)] = cnt_r[lidx(op_to_r)] + CW'(1);
      end
      S_FIN: begin
        if (outcome_r == OC_MISS) begin
          cnt_nxt[0] = cnt_r[0] + CW'(1);
        end else begin
          cnt_nxt[lidx(fnd_list_r)] = cnt_r[lidx(fnd_list_r)] - CW'(1);
        end
      end
      S_FIN2: begin
        cnt_nxt[1] = cnt_r[1] + CW'(1);
      end
      default: ;
    endcase
    if (cfg_wr_en) begin
      cap_nxt = cfg_wr_data;
      tgt_nxt = '0;
      for (int k = 0; k < 4; k++) begin
        cnt_nxt[k] = '0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= 7'd64;
      tgt_r       <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
      need_drop_r <= 1'b0;
      need_rep_r  <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      tgt_r       <= tgt_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
      need_drop_r <= need_drop_nxt;
      need_rep_r  <= need_rep_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    outcome_r   <= outcome_nxt;
    ev_v_r      <= ev_v_nxt;
    ev_pg_r     <= ev_pg_nxt;
    drop_list_r <= drop_list_nxt;
    drop_ev_r   <= drop_ev_nxt;
    rep_b2_r    <= rep_b2_nxt;
    op_from_r   <= op_from_nxt;
    op_to_r     <= op_to_nxt;
    op_ev_r     <= op_ev_nxt;
    q_rank_r    <= q_rank_nxt;
    div_num_r   <= div_num_nxt;
    div_den_r   <= div_den_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    fnd_any_r   <= fnd_any;
    fnd_list_r  <= fnd_list;
    fnd_rank_r  <= fnd_rank;
    fnd_idx_r   <= fnd_idx;
    lru_any_r   <= lru_any;
    lru_idx_r   <= lru_idx;
    lru_tag_r   <= lru_tag;
    free_any_r  <= c_free[DIR];
    free_idx_r  <= free_idx;
    if (ld_out) begin
      out_outcome_r <= outcome_r;
      out_ev_v_r    <= ev_v_r;
      out_ev_pg_r   <= ev_pg_r;
      out_tgt_r     <= tgt_r;
      out_hits_r    <= hits_r;
    end
  end

  // A new request is taken only while the sequencer is idle; a finished
  // result may still be waiting in the output register.
  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_outcome     = out_outcome_r;
  assign out_hit         = (out_outcome_r == OC_HIT);
  assign out_evict_valid = out_ev_v_r;
  assign out_evict_page  = out_ev_pg_r;
  assign out_target_size = TGT_W'(out_tgt_r);
  assign out_hit_total   = out_hits_r;

  `ASSERT_AT(a_tgt_cap, clk, rst_n, (pz <= cf), "target exceeds capacity")
  `ASSERT_AT(a_dir_size, clk, rst_n, (tot <= c2), "directory holds more than 2c tags")
  `ASSERT_AT(a_lru_found, clk, rst_n, (state_r == S_OPU) |-> lru_any_r, "LRU entry missing")
  `ASSERT_AT(a_free_slot, clk, rst_n, (state_r == S_FIN && outcome_r == OC_MISS) |-> free_any_r, "no free slot on insert")
  `ASSERT_NEXT(a_done_out, clk, rst_n, ld_out, out_valid, "result not presented")

endmodule
